// ----- rtl/core/rta_pkg.sv -----
// Shared types, widths and elaboration-time constant functions for the
// RSSI triangle angle block. No dependencies.
`default_nettype none
package rta_pkg;

	localparam int PowTableDepth = 256;
	localparam int AngleFracBits = 14;
	localparam int Log2TenTenthQ24 = 5573271;
	localparam int RatioLimit = 20;
	localparam int WideLimit = 22;
	localparam int CordicSteps = 30;
	localparam int SqrtSteps = 31;
	localparam int SqrtW = 62;
	localparam int ResW = 31;
	localparam int XyW = 34;
	localparam int ZW = 34;
	localparam int CosMagW = 15;

	localparam logic [1:0] REG_REF_A = 2'd0;
	localparam logic [1:0] REG_REF_B = 2'd1;
	localparam logic [1:0] REG_REF_C = 2'd2;
	localparam logic [1:0] REG_PLE = 2'd3;

	typedef struct packed {
		logic vld;
		logic ok;
		logic neg;
	} side_t;

	function automatic int depth_bits(input int depth);
		int s;
		s = 0;
		for (int t = 0; t < 12; t++) begin
			if ((2 << s) <= depth && s < 12)
				s = s + 1;
		end
		return s;
	endfunction

	function automatic longint unsigned isqrt64(input longint unsigned v_in);
		longint unsigned v;
		longint unsigned r;
		longint unsigned b;
		v = v_in;
		r = 0;
		b = 64'd1 << 62;
		for (int t = 0; t < 32; t++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Restoring long division, used only while the constant tables are built.
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned rem;
		q = 0;
		rem = 0;
		for (int t = 63; t >= 0; t--) begin
			rem = (rem << 1) | ((num >> t) & 64'd1);
			if (rem >= den) begin
				rem = rem - den;
				q = q | (64'd1 << t);
			end
		end
		return q;
	endfunction

	function automatic longint unsigned root_q30(input int j);
		longint unsigned r;
		r = 64'd2 << 30;
		for (int t = 1; t <= 12; t++) begin
			if (t <= j)
				r = isqrt64(r << 30);
		end
		return r;
	endfunction

	function automatic longint unsigned atan_pow2_q60(input int i);
		longint unsigned p;
		longint unsigned sum;
		longint unsigned term;
		p = (64'd1 << 60) >> i;
		sum = 0;
		for (int k = 0; k < 64; k++) begin
			if (p != 0) begin
				term = udiv64(p, 64'(2 * k + 1));
				if (k % 2 == 1)
					sum = sum - term;
				else
					sum = sum + term;
				p = p >> (2 * i);
			end
		end
		return sum;
	endfunction

	function automatic longint unsigned atan_third_q60();
		longint unsigned p;
		longint unsigned sum;
		longint unsigned term;
		p = (64'd1 << 60) / 3;
		sum = 0;
		for (int k = 0; k < 64; k++) begin
			if (p != 0) begin
				term = udiv64(p, 64'(2 * k + 1));
				if (k % 2 == 1)
					sum = sum - term;
				else
					sum = sum + term;
				p = p / 9;
			end
		end
		return sum;
	endfunction

	function automatic longint unsigned quarter_q60();
		return atan_pow2_q60(1) + atan_third_q60();
	endfunction

	function automatic longint unsigned atan_q30(input int i);
		longint unsigned a60;
		a60 = (i == 0) ? quarter_q60() : atan_pow2_q60(i);
		return (a60 + (64'd1 << 29)) >> 30;
	endfunction

	function automatic longint unsigned pi_q30();
		return (4 * quarter_q60() + (64'd1 << 29)) >> 30;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rta_pow_cell.sv -----
// One cell of the fractional power-of-two chain: multiplies three lanes by a
// fixed root of two where the lane's exponent bit is set. Uses rta_pkg.
`default_nettype none
module rta_pow_cell #(
	parameter int EW = 18,
	parameter int BITP = 0,
	parameter logic [rta_pkg::ResW-1:0] ROOT = '0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  rta_pkg::side_t                     side_i,
	input  logic [2:0][EW-1:0]                 e_i,
	input  logic [2:0][rta_pkg::ResW-1:0]      res_i,
	output rta_pkg::side_t                     side_o,
	output logic [2:0][EW-1:0]                 e_o,
	output logic [2:0][rta_pkg::ResW-1:0]      res_o
);

	logic [2:0][2*rta_pkg::ResW:0] rnd;
	logic [2:0][rta_pkg::ResW-1:0] nxt;
	rta_pkg::side_t side_q;
	logic [2:0][EW-1:0] e_q;
	logic [2:0][rta_pkg::ResW-1:0] res_q;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			rnd[l] = (2*rta_pkg::ResW+1)'(res_i[l]) * (2*rta_pkg::ResW+1)'(ROOT)
				+ ((2*rta_pkg::ResW+1)'(1) << 29);
			nxt[l] = e_i[l][BITP] ? rnd[l][30 +: rta_pkg::ResW] : res_i[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_q <= '0;
		else if (en)
			side_q <= side_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_q <= e_i;
			res_q <= nxt;
		end
	end

	assign side_o = side_q;
	assign e_o = e_q;
	assign res_o = res_q;

endmodule
`default_nettype wire

// ----- rtl/core/rta_sqrt_cell.sv -----
// One cell of the pipelined integer square root: settles one result bit.
// Uses rta_pkg.
`default_nettype none
module rta_sqrt_cell #(
	parameter int BIT = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  rta_pkg::side_t                side_i,
	input  logic [rta_pkg::SqrtW-1:0]     v_i,
	input  logic [rta_pkg::SqrtW-1:0]     r_i,
	input  logic [rta_pkg::ResW-1:0]      x_i,
	output rta_pkg::side_t                side_o,
	output logic [rta_pkg::SqrtW-1:0]     v_o,
	output logic [rta_pkg::SqrtW-1:0]     r_o,
	output logic [rta_pkg::ResW-1:0]      x_o
);

	localparam logic [rta_pkg::SqrtW-1:0] B = rta_pkg::SqrtW'(1) << (2 * BIT);

	logic [rta_pkg::SqrtW-1:0] t;
	logic [rta_pkg::SqrtW-1:0] v_n;
	logic [rta_pkg::SqrtW-1:0] r_n;
	rta_pkg::side_t side_q;
	logic [rta_pkg::SqrtW-1:0] v_q;
	logic [rta_pkg::SqrtW-1:0] r_q;
	logic [rta_pkg::ResW-1:0] x_q;

	always_comb begin
		t = r_i + B;
		if (v_i >= t) begin
			v_n = v_i - t;
			r_n = (r_i >> 1) + B;
		end else begin
			v_n = v_i;
			r_n = r_i >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_q <= '0;
		else if (en)
			side_q <= side_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_q <= v_n;
			r_q <= r_n;
			x_q <= x_i;
		end
	end

	assign side_o = side_q;
	assign v_o = v_q;
	assign r_o = r_q;
	assign x_o = x_q;

endmodule
`default_nettype wire

// ----- rtl/core/rta_cordic_cell.sv -----
// One vectoring CORDIC rotation with a fixed shift and arctangent step.
// Uses rta_pkg.
`default_nettype none
module rta_cordic_cell #(
	parameter int STEP = 0,
	parameter logic [rta_pkg::ZW-1:0] ANG = '0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  rta_pkg::side_t                       side_i,
	input  logic signed [rta_pkg::XyW-1:0]       x_i,
	input  logic signed [rta_pkg::XyW-1:0]       y_i,
	input  logic signed [rta_pkg::ZW-1:0]        z_i,
	output rta_pkg::side_t                       side_o,
	output logic signed [rta_pkg::XyW-1:0]       x_o,
	output logic signed [rta_pkg::XyW-1:0]       y_o,
	output logic signed [rta_pkg::ZW-1:0]        z_o
);

	logic signed [rta_pkg::XyW-1:0] xs;
	logic signed [rta_pkg::XyW-1:0] ys;
	logic signed [rta_pkg::XyW-1:0] x_n;
	logic signed [rta_pkg::XyW-1:0] y_n;
	logic signed [rta_pkg::ZW-1:0] z_n;
	rta_pkg::side_t side_q;
	logic signed [rta_pkg::XyW-1:0] x_q;
	logic signed [rta_pkg::XyW-1:0] y_q;
	logic signed [rta_pkg::ZW-1:0] z_q;

	always_comb begin
		xs = x_i >>> STEP;
		ys = y_i >>> STEP;
		if (!y_i[rta_pkg::XyW-1]) begin
			x_n = x_i + ys;
			y_n = y_i - xs;
			z_n = z_i + $signed(ANG);
		end else begin
			x_n = x_i - ys;
			y_n = y_i + xs;
			z_n = z_i - $signed(ANG);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			side_q <= '0;
		else if (en)
			side_q <= side_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
		end
	end

	assign side_o = side_q;
	assign x_o = x_q;
	assign y_o = y_q;
	assign z_o = z_q;

endmodule
`default_nettype wire

// ----- rtl/core/rssi_triangle_angle.sv -----
// Top level of the RSSI triangle angle block: front end, power-of-two,
// square root and CORDIC chains. Uses rta_pkg and the three cell modules.
//
// Usage: each request on the slave stream carries three RSSI readings in
// dBm (robot-phone, beacon-robot, beacon-phone). Every request yields one
// result on the master stream: the angle at the robot in radians with
// ANGLE_FRAC_BITS fraction bits in tdata, and a status flag in tuser
// (1 when the readings give no valid triangle, with angle 0).
// The pipeline has five front stages for the exponents, one power-of-two
// cell per exponent bit, four cosine stages, 31 square root cells, 30
// CORDIC cells and the output register. Throughput is one request per
// cycle while the receiver keeps taking results.
// The whole pipeline advances together; when the receiver holds tready low
// with a result waiting, the pipeline freezes and tready on the slave side
// falls until the result is taken.
// Reset clears all valid flags and loads the reference levels with -52 dBm
// and the path loss exponent with 3. Configuration writes take effect at once.
// Users make them only while no request is in flight; the block does not check.
`default_nettype none
module rssi_triangle_angle #(
	parameter int POW_TABLE_DEPTH = rta_pkg::PowTableDepth,
	parameter int ANGLE_FRAC_BITS = rta_pkg::AngleFracBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// rssi_robot_phone [7:0], rssi_beacon_robot [15:8], rssi_beacon_phone [23:16]
	input  logic [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// angle [15:0]
	output logic [15:0] m_axis_tdata,
	// status [0]
	output logic        m_axis_tuser,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int DB = rta_pkg::depth_bits(POW_TABLE_DEPTH);
	localparam int D = 1 << DB;
	localparam int EW = DB + 10;
	localparam int PW = DB + 34;
	localparam int M2W = PW - 24;
	localparam int RS = M2W + 1;
	localparam int RW = RS + 1;
	localparam int PRW = M2W + RW;
	localparam int F = ANGLE_FRAC_BITS;
	localparam int RW_PLUS = rta_pkg::ResW;
	localparam logic [RW-1:0] RECIP1 = RW'((64'd1 << RS) / 1);
	localparam logic [RW-1:0] RECIP2 = RW'((64'd1 << RS) / 2);
	localparam logic [RW-1:0] RECIP3 = RW'((64'd1 << RS) / 3);
	localparam logic [RW-1:0] RECIP4 = RW'((64'd1 << RS) / 4);
	localparam logic [RW-1:0] RECIP5 = RW'((64'd1 << RS) / 5);
	localparam logic [RW-1:0] RECIP6 = RW'((64'd1 << RS) / 6);
	localparam logic [RW-1:0] RECIP7 = RW'((64'd1 << RS) / 7);
	localparam logic [32:0] KQ24 = 33'(rta_pkg::Log2TenTenthQ24);
	localparam logic signed [EW-1:0] LIM_A = EW'(rta_pkg::RatioLimit * D);
	localparam logic signed [EW-1:0] LIM_W = EW'(rta_pkg::WideLimit * D);
	localparam logic signed [EW-1:0] NEG_LIM = EW'(-62 * D);
	localparam logic signed [rta_pkg::ZW-1:0] PI_Q30 = rta_pkg::ZW'(rta_pkg::pi_q30());
	localparam longint unsigned AMAX_RAW =
		(rta_pkg::pi_q30() + (64'd1 << (29 - F))) >> (30 - F);
	localparam logic [15:0] AMAX = (AMAX_RAW > 64'd65535) ? 16'hFFFF : 16'(AMAX_RAW);

	logic en;
	logic signed [7:0] ref_a_q;
	logic signed [7:0] ref_b_q;
	logic signed [7:0] ref_c_q;
	logic [2:0] ple_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_a_q <= -8'sd52;
			ref_b_q <= -8'sd52;
			ref_c_q <= -8'sd52;
			ple_q <= 3'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				rta_pkg::REG_REF_A: ref_a_q <= $signed(cfg_data);
				rta_pkg::REG_REF_B: ref_b_q <= $signed(cfg_data);
				rta_pkg::REG_REF_C: ref_c_q <= $signed(cfg_data);
				rta_pkg::REG_PLE: ple_q <= cfg_data[2:0];
				default: ple_q <= ple_q;
			endcase
		end
	end

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: level differences.
	logic signed [10:0] ea;
	logic signed [10:0] eb;
	logic signed [10:0] ec;
	logic [2:0] n_in;
	rta_pkg::side_t side_s1;
	logic signed [10:0] xu_s1;
	logic signed [10:0] xw_s1;
	logic [2:0] n_s1;

	always_comb begin
		ea = 11'(ref_a_q) - 11'($signed(s_axis_tdata[7:0]));
		eb = 11'(ref_b_q) - 11'($signed(s_axis_tdata[15:8]));
		ec = 11'(ref_c_q) - 11'($signed(s_axis_tdata[23:16]));
		n_in = (ple_q == 3'd0) ? 3'd1 : ple_q;
	end

	// Stage 2: scale by log2(10)/10 and the table depth, add the rounding term.
	logic [9:0] magu;
	logic [9:0] magw;
	logic [32:0] mu;
	logic [32:0] mw;
	rta_pkg::side_t side_s2;
	logic [PW-1:0] pu_s2;
	logic [PW-1:0] pw_s2;
	logic su_s2;
	logic sw_s2;
	logic [2:0] n_s2;

	always_comb begin
		magu = xu_s1[10] ? 10'(-xu_s1) : 10'(xu_s1);
		magw = xw_s1[10] ? 10'(-xw_s1) : 10'(xw_s1);
		mu = 33'(magu) * KQ24;
		mw = 33'(magw) * KQ24;
	end

	// Stage 3: divide by N through a reciprocal.
	logic [M2W-1:0] m2u;
	logic [M2W-1:0] m2w;
	logic [RW-1:0] rsel;
	rta_pkg::side_t side_s3;
	logic [PRW-1:0] pru_s3;
	logic [PRW-1:0] prw_s3;
	logic [M2W-1:0] m2u_s3;
	logic [M2W-1:0] m2w_s3;
	logic su_s3;
	logic sw_s3;
	logic [2:0] n_s3;

	always_comb begin
		m2u = pu_s2[PW-1:24];
		m2w = pw_s2[PW-1:24];
		case (n_s2)
			3'd2: rsel = RECIP2;
			3'd3: rsel = RECIP3;
			3'd4: rsel = RECIP4;
			3'd5: rsel = RECIP5;
			3'd6: rsel = RECIP6;
			3'd7: rsel = RECIP7;
			default: rsel = RECIP1;
		endcase
	end

	// Stage 4: quotient correction and sign.
	logic [M2W-1:0] qeu;
	logic [M2W-1:0] qew;
	logic [M2W+2:0] remu;
	logic [M2W+2:0] remw;
	logic [M2W-1:0] qu;
	logic [M2W-1:0] qw;
	rta_pkg::side_t side_s4;
	logic signed [EW-1:0] u_s4;
	logic signed [EW-1:0] w_s4;

	always_comb begin
		qeu = pru_s3[RS +: M2W];
		qew = prw_s3[RS +: M2W];
		remu = (M2W+3)'(m2u_s3) - (M2W+3)'(qeu) * (M2W+3)'(n_s3);
		remw = (M2W+3)'(m2w_s3) - (M2W+3)'(qew) * (M2W+3)'(n_s3);
		qu = qeu + M2W'(remu >= (M2W+3)'(n_s3));
		qw = qew + M2W'(remw >= (M2W+3)'(n_s3));
	end

	// Stage 5: exponents of the three powers and the range check.
	logic signed [EW-1:0] au;
	rta_pkg::side_t side_s5;
	logic [2:0][EW-1:0] e_s5;

	assign au = u_s4[EW-1] ? -u_s4 : u_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
		end else if (en) begin
			side_s1 <= '{vld: s_axis_tvalid, ok: 1'b1, neg: 1'b0};
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= '{vld: side_s4.vld, ok: (au < LIM_A) && (w_s4 < LIM_W), neg: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xu_s1 <= ea - eb;
			xw_s1 <= (ec <<< 1) - ea - eb;
			n_s1 <= n_in;
			pu_s2 <= (PW'(mu) << DB) + (PW'(n_s1) << 23);
			pw_s2 <= (PW'(mw) << DB) + (PW'(n_s1) << 23);
			su_s2 <= xu_s1[10];
			sw_s2 <= xw_s1[10];
			n_s2 <= n_s1;
			pru_s3 <= PRW'(m2u) * PRW'(rsel);
			prw_s3 <= PRW'(m2w) * PRW'(rsel);
			m2u_s3 <= m2u;
			m2w_s3 <= m2w;
			su_s3 <= su_s2;
			sw_s3 <= sw_s2;
			n_s3 <= n_s2;
			u_s4 <= su_s3 ? -EW'(qu) : EW'(qu);
			w_s4 <= sw_s3 ? -EW'(qw) : EW'(qw);
			e_s5[0] <= au;
			e_s5[1] <= -au;
			e_s5[2] <= w_s4;
		end
	end

	// Fractional power-of-two chain, one cell per exponent bit.
	rta_pkg::side_t ch_s [0:DB];
	logic [2:0][EW-1:0] ch_e [0:DB];
	logic [2:0][RW_PLUS-1:0] ch_r [0:DB];

	assign ch_s[0] = side_s5;
	assign ch_e[0] = e_s5;
	assign ch_r[0] = {3{RW_PLUS'(1) << 30}};

	for (genvar j = 1; j <= DB; j++) begin : g_pow
		rta_pow_cell #(
			.EW   (EW),
			.BITP (DB - j),
			.ROOT (RW_PLUS'(rta_pkg::root_q30(j)))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.side_i (ch_s[j-1]),
			.e_i    (ch_e[j-1]),
			.res_i  (ch_r[j-1]),
			.side_o (ch_s[j]),
			.e_o    (ch_e[j]),
			.res_o  (ch_r[j])
		);
	end

	// Stage 6: integer part of each exponent as a shift.
	logic signed [EW-1:0] ie [0:2];
	logic [5:0] nsh [0:2];
	logic [63:0] pv [0:2];
	rta_pkg::side_t side_s6;
	logic [2:0][52:0] p_s6;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			ie[l] = $signed(ch_e[DB][l]) >>> DB;
			nsh[l] = 6'(-ie[l]);
			if ($signed(ch_e[DB][l]) < NEG_LIM)
				pv[l] = '0;
			else if (!ie[l][EW-1])
				pv[l] = 64'(ch_r[DB][l]) << ie[l][5:0];
			else
				pv[l] = (64'(ch_r[DB][l]) + (64'd1 << (nsh[l] - 6'd1))) >> nsh[l];
		end
	end

	// Stage 7: twice the cosine; stage 8: Q1.14 cosine magnitude and range check.
	rta_pkg::side_t side_s7;
	logic signed [54:0] p_s7;
	logic [54:0] pmag;
	logic [37:0] cq;
	rta_pkg::side_t side_s8;
	logic [rta_pkg::CosMagW-1:0] cm_s8;

	always_comb begin
		pmag = p_s7[54] ? 55'(-p_s7) : 55'(p_s7);
		cq = 38'((pmag + 55'(1 << 16)) >> 17);
	end

	// Stage 9: sine squared as the square root operand.
	rta_pkg::side_t side_s9;
	logic [rta_pkg::SqrtW-1:0] v_s9;
	logic [rta_pkg::ResW-1:0] x_s9;
	logic [29:0] csq;

	assign csq = 30'(cm_s8) * 30'(cm_s8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s6 <= '0;
			side_s7 <= '0;
			side_s8 <= '0;
			side_s9 <= '0;
		end else if (en) begin
			side_s6 <= ch_s[DB];
			side_s7 <= side_s6;
			side_s8 <= '{vld: side_s7.vld, ok: side_s7.ok && (cq <= 38'd16384),
				neg: p_s7[54] && (cq != 38'd0)};
			side_s9 <= side_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++)
				p_s6[l] <= pv[l][52:0];
			p_s7 <= $signed(55'(p_s6[0])) + $signed(55'(p_s6[1])) - $signed(55'(p_s6[2]));
			cm_s8 <= cq[rta_pkg::CosMagW-1:0];
			v_s9 <= (rta_pkg::SqrtW'(1) << 60) - (rta_pkg::SqrtW'(csq) << 32);
			x_s9 <= rta_pkg::ResW'(cm_s8) << 16;
		end
	end

	// Square root chain.
	rta_pkg::side_t sq_s [0:rta_pkg::SqrtSteps];
	logic [rta_pkg::SqrtW-1:0] sq_v [0:rta_pkg::SqrtSteps];
	logic [rta_pkg::SqrtW-1:0] sq_r [0:rta_pkg::SqrtSteps];
	logic [rta_pkg::ResW-1:0] sq_x [0:rta_pkg::SqrtSteps];

	assign sq_s[0] = side_s9;
	assign sq_v[0] = v_s9;
	assign sq_r[0] = '0;
	assign sq_x[0] = x_s9;

	for (genvar t = 0; t < rta_pkg::SqrtSteps; t++) begin : g_sqrt
		rta_sqrt_cell #(
			.BIT (rta_pkg::SqrtSteps - 1 - t)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.side_i (sq_s[t]),
			.v_i    (sq_v[t]),
			.r_i    (sq_r[t]),
			.x_i    (sq_x[t]),
			.side_o (sq_s[t+1]),
			.v_o    (sq_v[t+1]),
			.r_o    (sq_r[t+1]),
			.x_o    (sq_x[t+1])
		);
	end

	// CORDIC chain.
	rta_pkg::side_t cd_s [0:rta_pkg::CordicSteps];
	logic signed [rta_pkg::XyW-1:0] cd_x [0:rta_pkg::CordicSteps];
	logic signed [rta_pkg::XyW-1:0] cd_y [0:rta_pkg::CordicSteps];
	logic signed [rta_pkg::ZW-1:0] cd_z [0:rta_pkg::CordicSteps];

	assign cd_s[0] = sq_s[rta_pkg::SqrtSteps];
	assign cd_x[0] = $signed(rta_pkg::XyW'(sq_x[rta_pkg::SqrtSteps]));
	assign cd_y[0] = $signed(rta_pkg::XyW'(sq_r[rta_pkg::SqrtSteps]));
	assign cd_z[0] = '0;

	for (genvar t = 0; t < rta_pkg::CordicSteps; t++) begin : g_cordic
		rta_cordic_cell #(
			.STEP (t),
			.ANG  (rta_pkg::ZW'(rta_pkg::atan_q30(t)))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.side_i (cd_s[t]),
			.x_i    (cd_x[t]),
			.y_i    (cd_y[t]),
			.z_i    (cd_z[t]),
			.side_o (cd_s[t+1]),
			.x_o    (cd_x[t+1]),
			.y_o    (cd_y[t+1]),
			.z_o    (cd_z[t+1])
		);
	end

	// Output stage: fold into [0, pi], round and register.
	logic signed [rta_pkg::ZW-1:0] zf;
	logic signed [rta_pkg::ZW-1:0] zc;
	logic [rta_pkg::ZW-1:0] zr;
	logic [15:0] ang;
	rta_pkg::side_t side_out;
	logic out_vld_q;
	logic [15:0] out_angle_q;
	logic out_status_q;

	assign side_out = cd_s[rta_pkg::CordicSteps];

	always_comb begin
		zf = side_out.neg ? PI_Q30 - cd_z[rta_pkg::CordicSteps] : cd_z[rta_pkg::CordicSteps];
		if (zf[rta_pkg::ZW-1])
			zc = '0;
		else if (zf > PI_Q30)
			zc = PI_Q30;
		else
			zc = zf;
		zr = ($unsigned(zc) + (rta_pkg::ZW'(1) << (29 - F))) >> (30 - F);
		ang = (zr > rta_pkg::ZW'(65535)) ? 16'hFFFF : zr[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= side_out.vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_angle_q <= side_out.ok ? ang : 16'd0;
			out_status_q <= !side_out.ok;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_angle_q;
	assign m_axis_tuser = out_status_q;

`ifndef NO_ASSERTIONS
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
		else $error("status set with a non-zero angle");

	a_angle_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata <= AMAX)
		else $error("angle beyond pi");

	a_sine_range: assert property (@(posedge clk) disable iff (!arst_n)
		sq_s[rta_pkg::SqrtSteps].vld && sq_s[rta_pkg::SqrtSteps].ok
		|-> sq_r[rta_pkg::SqrtSteps] <= (rta_pkg::SqrtW'(1) << 30))
		else $error("sine above one");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		side_s8.vld && !en |=> side_s8.vld)
		else $error("request lost in a stalled pipeline");
`endif

endmodule
`default_nettype wire
